>>> rtl/ffba_pkg.sv
// Shared constants, codes and controller/datapath interface types of the block allocator.
`timescale 1ns / 1ps

package ffba_pkg;

    // Table geometry
    localparam int BLOCKS    = 16;
    localparam int SIZE_BITS = 16;
    localparam int IDX_BITS  = $clog2(BLOCKS);
    localparam int CNT_BITS  = $clog2(BLOCKS + 1);

    // Configuration register
    localparam int CFG_BITS  = 5;
    localparam int CMP_BITS  = (CNT_BITS > CFG_BITS) ? CNT_BITS : CFG_BITS;
    localparam logic [CFG_BITS-1:0] CFG_RESET = CFG_BITS'(16);

    // Field widths of the command and result transactions
    localparam int OP_W    = 2;
    localparam int EIDX_W  = 4;
    localparam int AMT_W   = 16;
    localparam int OWN_W   = 8;
    localparam int STAT_W  = 2;

    // Opcodes
    localparam logic [OP_W-1:0] OP_SET     = 2'd0;
    localparam logic [OP_W-1:0] OP_ALLOC   = 2'd1;
    localparam logic [OP_W-1:0] OP_COMPACT = 2'd2;
    localparam logic [OP_W-1:0] OP_READ    = 2'd3;

    // Result status codes
    localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STAT_W-1:0] ST_NOFIT = 2'd1;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;

    // Kind of result the controller asks the datapath to register
    localparam logic [1:0] RES_ACCESS  = 2'd0;
    localparam logic [1:0] RES_ALLOC   = 2'd1;
    localparam logic [1:0] RES_NOFIT   = 2'd2;
    localparam logic [1:0] RES_COMPACT = 2'd3;

    // Controller to datapath commands
    typedef struct packed {
        logic       load;
        logic       access;
        logic       alloc_step;
        logic       move_step;
        logic       fill_step;
        logic       emit;
        logic [1:0] emit_kind;
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic idx_ok;
        logic hit;
        logic src_end;
        logic dst_end;
    } t_stat;

endpackage

>>> rtl/ffba_datapath.sv
// Datapath of the block allocator: partition tables, scan pointers, config and result registers.
`timescale 1ns / 1ps

module ffba_datapath (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  ffba_pkg::t_cmd                      i_cmd,
    output ffba_pkg::t_stat                     o_stat,
    input  logic [ffba_pkg::OP_W-1:0]           i_opcode,
    input  logic [ffba_pkg::EIDX_W-1:0]         i_entry_index,
    input  logic [ffba_pkg::AMT_W-1:0]          i_amount,
    input  logic [ffba_pkg::OWN_W-1:0]          i_owner_id,
    input  logic                                i_cfg_we,
    input  logic [ffba_pkg::CFG_BITS-1:0]       i_cfg_data,
    output logic                                o_result_valid,
    output logic [ffba_pkg::STAT_W-1:0]         o_status,
    output logic [ffba_pkg::EIDX_W-1:0]         o_block_index,
    output logic [ffba_pkg::OWN_W-1:0]          o_owner,
    output logic [ffba_pkg::AMT_W-1:0]          o_size
);

    // Partition tables
    logic [ffba_pkg::OWN_W-1:0]     r_owner_tab [ffba_pkg::BLOCKS];
    logic [ffba_pkg::SIZE_BITS-1:0] r_size_tab  [ffba_pkg::BLOCKS];

    // Latched command
    logic [ffba_pkg::OP_W-1:0]      r_op;
    logic [ffba_pkg::EIDX_W-1:0]    r_idx;
    logic [ffba_pkg::SIZE_BITS-1:0] r_amt;
    logic [ffba_pkg::OWN_W-1:0]     r_own;

    // Scan pointers
    logic [ffba_pkg::CNT_BITS-1:0]  r_src, n_src;
    logic [ffba_pkg::CNT_BITS-1:0]  r_dst, n_dst;

    // Configuration
    logic [ffba_pkg::CFG_BITS-1:0]  r_cfg;
    logic [ffba_pkg::CMP_BITS-1:0]  cfg_ext;
    logic [ffba_pkg::CMP_BITS-1:0]  eff_cnt;

    // Table access
    logic [ffba_pkg::IDX_BITS-1:0]  rd_addr;
    logic [ffba_pkg::OWN_W-1:0]     rd_owner;
    logic [ffba_pkg::SIZE_BITS-1:0] rd_size;
    logic                           wr_en;
    logic [ffba_pkg::IDX_BITS-1:0]  wr_addr;
    logic [ffba_pkg::OWN_W-1:0]     wr_owner;
    logic [ffba_pkg::SIZE_BITS-1:0] wr_size;

    // Result registers
    logic                           r_result_valid;
    logic [ffba_pkg::STAT_W-1:0]    r_res_status, n_res_status;
    logic [ffba_pkg::EIDX_W-1:0]    r_res_index, n_res_index;
    logic [ffba_pkg::OWN_W-1:0]     r_res_owner, n_res_owner;
    logic [ffba_pkg::AMT_W-1:0]     r_res_size, n_res_size;

    logic idx_ok;
    logic hit;

    // Effective partition count: min(blocks_in_use, BLOCKS)
    assign cfg_ext = ffba_pkg::CMP_BITS'(r_cfg);
    assign eff_cnt = (cfg_ext < ffba_pkg::CMP_BITS'(ffba_pkg::BLOCKS)) ?
                     cfg_ext : ffba_pkg::CMP_BITS'(ffba_pkg::BLOCKS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= ffba_pkg::CFG_RESET;
        end else if (i_cfg_we) begin
            r_cfg <= i_cfg_data;
        end
    end

    // Latch the command transaction
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op  <= i_opcode;
            r_idx <= i_entry_index;
            r_amt <= ffba_pkg::SIZE_BITS'(i_amount);
            r_own <= i_owner_id;
        end
    end

    // Single read port: addressed entry on set/read, scan pointer otherwise
    assign rd_addr  = i_cmd.access ? ffba_pkg::IDX_BITS'(r_idx) : r_src[ffba_pkg::IDX_BITS-1:0];
    assign rd_owner = r_owner_tab[rd_addr];
    assign rd_size  = r_size_tab[rd_addr];

    assign idx_ok = ffba_pkg::CMP_BITS'(r_idx) < eff_cnt;
    assign hit    = (rd_owner == '0) && (rd_size >= r_amt);

    assign o_stat.idx_ok  = idx_ok;
    assign o_stat.hit     = hit;
    assign o_stat.src_end = ffba_pkg::CMP_BITS'(r_src) >= eff_cnt;
    assign o_stat.dst_end = ffba_pkg::CMP_BITS'(r_dst) >= eff_cnt;

    // Single write port
    always_comb begin
        wr_en    = 1'b0;
        wr_addr  = rd_addr;
        wr_owner = rd_owner;
        wr_size  = r_amt;
        if (i_cmd.access && idx_ok && (r_op == ffba_pkg::OP_SET)) begin
            // set capacity keeps the owner
            wr_en = 1'b1;
        end else if (i_cmd.alloc_step && hit) begin
            wr_en    = 1'b1;
            wr_owner = r_own;
        end else if (i_cmd.move_step && (rd_owner != '0)) begin
            wr_en   = 1'b1;
            wr_addr = r_dst[ffba_pkg::IDX_BITS-1:0];
            wr_size = rd_size;
        end else if (i_cmd.fill_step) begin
            wr_en    = 1'b1;
            wr_addr  = r_dst[ffba_pkg::IDX_BITS-1:0];
            wr_owner = '0;
            wr_size  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < ffba_pkg::BLOCKS; i++) begin
                r_owner_tab[i] <= '0;
                r_size_tab[i]  <= '0;
            end
        end else if (wr_en) begin
            r_owner_tab[wr_addr] <= wr_owner;
            r_size_tab[wr_addr]  <= wr_size;
        end
    end

    // Scan pointers: src walks the tables, dst trails it during compaction
    always_comb begin
        n_src = r_src;
        n_dst = r_dst;
        if (i_cmd.load) begin
            n_src = '0;
            n_dst = '0;
        end else if (i_cmd.alloc_step && !hit) begin
            n_src = r_src + 1'b1;
        end else if (i_cmd.move_step) begin
            n_src = r_src + 1'b1;
            if (rd_owner != '0) begin
                n_dst = r_dst + 1'b1;
            end
        end else if (i_cmd.fill_step) begin
            n_dst = r_dst + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src <= '0;
            r_dst <= '0;
        end else begin
            r_src <= n_src;
            r_dst <= n_dst;
        end
    end

    // Result fields
    always_comb begin
        n_res_status = ffba_pkg::ST_DONE;
        n_res_index  = '0;
        n_res_owner  = '0;
        n_res_size   = '0;
        case (i_cmd.emit_kind)
            ffba_pkg::RES_ACCESS: begin
                n_res_index = r_idx;
                if (idx_ok) begin
                    n_res_owner = rd_owner;
                    n_res_size  = (r_op == ffba_pkg::OP_SET) ?
                                  ffba_pkg::AMT_W'(r_amt) : ffba_pkg::AMT_W'(rd_size);
                end else begin
                    n_res_status = ffba_pkg::ST_RANGE;
                end
            end
            ffba_pkg::RES_ALLOC: begin
                n_res_index = ffba_pkg::EIDX_W'(r_src);
                n_res_owner = r_own;
                n_res_size  = ffba_pkg::AMT_W'(r_amt);
            end
            ffba_pkg::RES_NOFIT: begin
                n_res_status = ffba_pkg::ST_NOFIT;
            end
            default: begin
                n_res_status = ffba_pkg::ST_DONE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_result_valid <= 1'b0;
        end else begin
            r_result_valid <= i_cmd.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_res_status <= n_res_status;
            r_res_index  <= n_res_index;
            r_res_owner  <= n_res_owner;
            r_res_size   <= n_res_size;
        end
    end

    assign o_result_valid = r_result_valid;
    assign o_status       = r_res_status;
    assign o_block_index  = r_res_index;
    assign o_owner        = r_res_owner;
    assign o_size         = r_res_size;

    // Every operation yields one result, so strobes never come back to back
    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_result_valid |=> !r_result_valid)
        else $error("result strobe held for two cycles");

    // Partitions beyond the effective count are never written
    a_wr_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |-> (ffba_pkg::CMP_BITS'(wr_addr) < eff_cnt))
        else $error("table write outside partitions in use");

    // Compaction destination never passes the source
    a_dst_behind_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.move_step |=> (r_dst <= r_src))
        else $error("compaction destination ahead of source");

endmodule

>>> rtl/ffba_ctrl.sv
// Controller state machine of the block allocator: sequences set, read, allocate and compact.
`timescale 1ns / 1ps

module ffba_ctrl (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [ffba_pkg::OP_W-1:0]  i_opcode,
    input  ffba_pkg::t_stat            i_stat,
    output ffba_pkg::t_cmd             o_cmd,
    output logic                       o_busy
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_ACCESS = 3'd1;
    localparam logic [2:0] S_ALLOC  = 3'd2;
    localparam logic [2:0] S_MOVE   = 3'd3;
    localparam logic [2:0] S_FILL   = 3'd4;

    logic [2:0] r_state, n_state;

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    case (i_opcode)
                        ffba_pkg::OP_ALLOC:   n_state = S_ALLOC;
                        ffba_pkg::OP_COMPACT: n_state = S_MOVE;
                        default:              n_state = S_ACCESS;
                    endcase
                end
            end
            S_ACCESS: begin
                o_cmd.access    = 1'b1;
                o_cmd.emit      = 1'b1;
                o_cmd.emit_kind = ffba_pkg::RES_ACCESS;
                n_state         = S_IDLE;
            end
            S_ALLOC: begin
                if (i_stat.src_end) begin
                    o_cmd.emit      = 1'b1;
                    o_cmd.emit_kind = ffba_pkg::RES_NOFIT;
                    n_state         = S_IDLE;
                end else begin
                    o_cmd.alloc_step = 1'b1;
                    if (i_stat.hit) begin
                        o_cmd.emit      = 1'b1;
                        o_cmd.emit_kind = ffba_pkg::RES_ALLOC;
                        n_state         = S_IDLE;
                    end
                end
            end
            S_MOVE: begin
                if (i_stat.src_end) begin
                    n_state = S_FILL;
                end else begin
                    o_cmd.move_step = 1'b1;
                end
            end
            S_FILL: begin
                if (i_stat.dst_end) begin
                    o_cmd.emit      = 1'b1;
                    o_cmd.emit_kind = ffba_pkg::RES_COMPACT;
                    n_state         = S_IDLE;
                end else begin
                    o_cmd.fill_step = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != S_IDLE);

    // An accepted command always starts work
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy)
        else $error("accepted command did not raise busy");

    // Work only ends on the cycle that hands a result to the datapath
    a_end_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(o_busy) |-> $past(o_cmd.emit))
        else $error("operation ended without a result");

endmodule

>>> rtl/first_fit_block_allocator.sv
// Top level of the first-fit partition allocator with compaction.
//
// Usage:
//   Command channel: a transaction is taken at a rising edge with start high and
//   busy low (opcode, entry index, amount, owner id). One command is in work at a time.
//   Result channel: o_result_valid is high for exactly one cycle with status, block
//   index, owner and size; the receiver cannot stall and must take it then.
//   Config channel: i_cfg_valid/o_cfg_ready write blocks_in_use (n = min(value, 16));
//   ready is always high. Write it only while the block is idle.
// Sequence from the accepting edge to the result strobe (n partitions in use):
//   set / read entry: the access state registers the result.
//   allocate: the scan tests partitions from 0 up to n - 1 and ends on the first fit.
//   compact: one pass over the sources, then clearing the tail, both through the
//   single table read/write port, one entry per cycle.
// busy drops in the cycle the result is shown, so a new command may be taken there.
// Reset (synchronous, active low) empties both tables, sets blocks_in_use to 16 and
// returns the controller to idle; no result is pending afterwards.
`timescale 1ns / 1ps

module first_fit_block_allocator (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [ffba_pkg::OP_W-1:0]           i_opcode,
    input  logic [ffba_pkg::EIDX_W-1:0]         i_entry_index,
    input  logic [ffba_pkg::AMT_W-1:0]          i_amount,
    input  logic [ffba_pkg::OWN_W-1:0]          i_owner_id,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [ffba_pkg::CFG_BITS-1:0]       i_cfg_data,
    output logic                                o_result_valid,
    output logic [ffba_pkg::STAT_W-1:0]         o_status,
    output logic [ffba_pkg::EIDX_W-1:0]         o_block_index,
    output logic [ffba_pkg::OWN_W-1:0]          o_owner,
    output logic [ffba_pkg::AMT_W-1:0]          o_size
);

    ffba_pkg::t_cmd  cmd;
    ffba_pkg::t_stat stat;

    // Config register is always writable
    assign o_cfg_ready = 1'b1;

    ffba_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_opcode (i_opcode),
        .i_stat   (stat),
        .o_cmd    (cmd),
        .o_busy   (busy)
    );

    ffba_datapath u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_opcode       (i_opcode),
        .i_entry_index  (i_entry_index),
        .i_amount       (i_amount),
        .i_owner_id     (i_owner_id),
        .i_cfg_we       (i_cfg_valid),
        .i_cfg_data     (i_cfg_data),
        .o_result_valid (o_result_valid),
        .o_status       (o_status),
        .o_block_index  (o_block_index),
        .o_owner        (o_owner),
        .o_size         (o_size)
    );

endmodule
